FILE: src/glt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glt_pkg: shared types and constants of the G-code line tokenizer
// Token kinds, lexer modes and the token record passed between stages.
// ----------------------------------------------------------------------------
package glt_pkg;

    localparam int MANT_BITS = 32;

    // token queue size and pointer width
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = 3;

    typedef enum logic [3:0] {
        K_COMMENT  = 4'd0,
        K_PROGRAM  = 4'd1,
        K_STAR     = 4'd2,
        K_CHECKSUM = 4'd3,
        K_LINENUM  = 4'd4,
        K_COMMAND  = 4'd5,
        K_PARAM    = 4'd6,
        K_NUMBER   = 4'd7,
        K_EOL      = 4'd8,
        K_ERROR    = 4'd9
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE       = 3'd0,
        M_PAREN      = 3'd1,
        M_SKIP       = 3'd2,
        M_NUM_NODIG  = 3'd3,
        M_NUM_DIG    = 3'd4,
        M_CSUM_NODIG = 3'd5,
        M_CSUM_DIG   = 3'd6,
        M_HALT       = 3'd7
    } t_mode;

    // one token as it travels from the lexer to the output side
    typedef struct packed {
        t_kind                 kind;
        logic [6:0]            letter;
        logic [MANT_BITS-1:0]  mantissa;
        logic [3:0]            frac;
        logic [7:0]            csum;
        logic                  last;
    } t_token;

    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;

endpackage

FILE: src/glt_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glt_lexer: front part of the tokenizer
// Takes one byte a beat, updates lexer state and checksum, and produces up to
// five tokens for that byte as a bundle with a count.
// ----------------------------------------------------------------------------
module glt_lexer import glt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_take,
    input  logic [7:0]   i_char,
    input  logic         i_end,
    output t_token [4:0] o_tok,
    output logic [2:0]   o_cnt
);

    localparam logic [MANT_BITS-1:0] TOP = {1'b1, {(MANT_BITS-1){1'b0}}};

    t_mode                r_mode, n_mode;
    logic [7:0]           r_xor, n_xor;
    logic                 r_bstar, n_bstar;
    logic                 r_hspace, n_hspace;
    logic [MANT_BITS-1:0] r_acc, n_acc;
    logic                 r_neg, n_neg;
    logic                 r_pt, n_pt;
    logic [3:0]           r_fc, n_fc;

    // digit accumulate with saturation
    logic [3:0]             dig;
    logic                   is_dig, is_ws, is_letter;
    logic [MANT_BITS-1:0]   lim, acc10;
    logic [MANT_BITS+3:0]   acc10w;
    logic                   fits;

    always_comb begin
        is_dig    = (i_char >= 8'h30) && (i_char <= 8'h39);
        dig       = i_char[3:0];
        is_ws     = (i_char == C_SPACE) || ((i_char >= 8'd9) && (i_char <= 8'd13));
        is_letter = ((i_char >= 8'h41) && (i_char <= 8'h5A))
                 || ((i_char >= 8'h61) && (i_char <= 8'h7A));
        lim       = r_neg ? TOP : TOP - 1'b1;
        // acc*10 + digit in a wider word; it fits when it stays within the limit
        acc10w    = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1)
                  + (MANT_BITS+4)'(dig);
        fits      = acc10w <= {4'd0, lim};
        acc10     = acc10w[MANT_BITS-1:0];
    end

    // per-byte lexing
    always_comb begin
        t_token t;
        logic   relex;
        logic [7:0] up;
        logic [MANT_BITS-1:0] sval;
        n_mode = r_mode; n_xor = r_xor; n_bstar = r_bstar; n_hspace = r_hspace;
        n_acc = r_acc; n_neg = r_neg; n_pt = r_pt; n_fc = r_fc;
        o_cnt = '0;
        relex = 1'b0;
        up    = i_char & 8'hDF;
        sval  = r_neg ? (~r_acc + 1'b1) : r_acc;
        o_tok = '0;
        t     = '0;

        if (r_bstar && r_mode != M_PAREN && r_mode != M_SKIP && r_mode != M_HALT) begin
            if (r_hspace && i_char != C_STAR) n_xor = n_xor ^ C_SPACE;
            n_hspace = 1'b0;
            if (i_char == C_SPACE && !i_end) n_hspace = 1'b1;
            else if (i_char != C_STAR) n_xor = n_xor ^ i_char;
        end

        case (r_mode)
            M_PAREN: begin
                if (i_char == C_RPAR) begin
                    t.kind = K_COMMENT; o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                    n_mode = M_IDLE;
                end
            end
            M_NUM_NODIG, M_NUM_DIG: begin
                if (is_dig) begin
                    if (r_pt) begin
                        if (fits && r_fc < 4'd9) begin
                            n_acc = acc10; n_fc = r_fc + 1'b1;
                        end
                    end else begin
                        n_acc = fits ? acc10 : lim;
                    end
                    n_mode = M_NUM_DIG;
                end else if (i_char == 8'h2E && !r_pt) begin
                    n_pt = 1'b1;
                end else if (r_mode == M_NUM_DIG) begin
                    t = '0; t.kind = K_NUMBER; t.mantissa = sval; t.frac = r_fc;
                    o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                    n_mode = M_IDLE; relex = 1'b1;
                end else begin
                    t = '0; t.kind = K_ERROR; o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                    n_mode = M_HALT;
                end
            end
            M_CSUM_NODIG, M_CSUM_DIG: begin
                if (is_dig) begin
                    n_acc  = fits ? acc10 : lim;
                    n_mode = M_CSUM_DIG;
                end else if (r_mode == M_CSUM_DIG) begin
                    t = '0; t.kind = K_CHECKSUM; t.mantissa = r_acc;
                    o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                    n_mode = M_IDLE; relex = 1'b1;
                end else begin
                    t = '0; t.kind = K_ERROR; o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                    n_mode = M_HALT;
                end
            end
            M_IDLE: relex = 1'b1;
            default: ;
        endcase

        // token start from idle
        if (relex && !is_ws) begin
            t = '0;
            if (i_char == C_SEMI) begin
                t.kind = K_COMMENT; o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                n_mode = M_SKIP;
            end else if (i_char == C_PCT) begin
                t.kind = K_PROGRAM; o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                n_mode = M_SKIP;
            end else if (i_char == C_LPAR) begin
                n_mode = M_PAREN;
            end else if (i_char == C_STAR) begin
                n_bstar = 1'b0;
                t.kind = K_STAR; t.letter = C_STAR[6:0];
                o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                n_acc = '0; n_neg = 1'b0; n_pt = 1'b0; n_fc = '0;
                n_mode = M_CSUM_NODIG;
            end else if (is_letter) begin
                if (up == 8'h4E) t.kind = K_LINENUM;
                else if (up == 8'h47 || up == 8'h4D || up == 8'h54 || up == 8'h4F)
                    t.kind = K_COMMAND;
                else t.kind = K_PARAM;
                t.letter = up[6:0];
                o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
            end else if (is_dig) begin
                n_acc = MANT_BITS'(dig); n_neg = 1'b0; n_pt = 1'b0; n_fc = '0;
                n_mode = M_NUM_DIG;
            end else if (i_char == 8'h2B || i_char == 8'h2D) begin
                n_acc = '0; n_neg = (i_char == 8'h2D); n_pt = 1'b0; n_fc = '0;
                n_mode = M_NUM_NODIG;
            end else begin
                t.kind = K_ERROR; o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                n_mode = M_HALT;
            end
        end

        // end of line flush
        if (i_end) begin
            t = '0;
            sval = n_neg ? (~n_acc + 1'b1) : n_acc;
            if (n_mode == M_NUM_DIG) begin
                t.kind = K_NUMBER; t.mantissa = sval; t.frac = n_fc;
                o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
            end else if (n_mode == M_CSUM_DIG) begin
                t.kind = K_CHECKSUM; t.mantissa = n_acc;
                o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
            end else if (n_mode == M_PAREN) begin
                t.kind = K_COMMENT; o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
            end else if (n_mode == M_NUM_NODIG || n_mode == M_CSUM_NODIG) begin
                t.kind = K_ERROR; o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                n_mode = M_HALT;
            end
            if (n_mode != M_HALT && n_bstar) begin
                t = '0; t.kind = K_STAR; t.letter = C_STAR[6:0];
                o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
                t = '0; t.kind = K_CHECKSUM; t.mantissa = MANT_BITS'(n_xor);
                o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
            end
            t = '0; t.kind = K_EOL; o_tok[o_cnt] = t; o_cnt = o_cnt + 1'b1;
        end

        // checksum seen by the tokens is the sum after this byte
        for (int k = 0; k < 5; k++) begin
            o_tok[k].csum = n_xor;
            o_tok[k].last = (3'(k) == o_cnt - 1'b1);
        end
        // note: the eol and all tokens report pre-reset sum, matching the line

        if (i_end) begin
            n_mode = M_IDLE; n_xor = '0; n_bstar = 1'b1; n_hspace = 1'b0;
            n_acc = '0; n_neg = 1'b0; n_pt = 1'b0; n_fc = '0;
        end
    end

    // lexer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_xor <= '0; r_bstar <= 1'b1; r_hspace <= 1'b0;
            r_acc <= '0; r_neg <= 1'b0; r_pt <= 1'b0; r_fc <= '0;
        end else if (i_take) begin
            r_mode <= n_mode; r_xor <= n_xor; r_bstar <= n_bstar;
            r_hspace <= n_hspace; r_acc <= n_acc; r_neg <= n_neg;
            r_pt <= n_pt; r_fc <= n_fc;
        end
    end

endmodule

FILE: src/glt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glt_queue: token queue between lexer and output side
// Takes a bundle of up to five tokens in one beat, drains one per cycle while i_pop is high.
// ----------------------------------------------------------------------------
module glt_queue import glt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  t_token [4:0] i_tok,
    input  logic [2:0]   i_cnt,
    output logic         o_room,
    output logic         o_valid,
    output t_token       o_tok,
    input  logic         i_pop
);

    t_token          mem [Q_DEPTH];
    logic [Q_AW-1:0] r_rd, r_wr;
    logic [Q_AW:0]   r_fill, n_fill;
    logic [Q_AW:0]   pop_n;

    always_comb begin
        pop_n   = {{Q_AW{1'b0}}, i_pop && (r_fill != '0)};
        n_fill  = r_fill + (i_wr ? (Q_AW+1)'(i_cnt) : '0) - pop_n;
        // room for a full five-token bundle
        o_room  = r_fill <= (Q_AW+1)'(Q_DEPTH - 5);
        o_valid = r_fill != '0;
        o_tok   = mem[r_rd];
    end

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            for (int k = 0; k < 5; k++) begin
                if (3'(k) < i_cnt) mem[r_wr + Q_AW'(k)] <= i_tok[k];
            end
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_fill <= '0;
        end else begin
            if (i_wr) r_wr <= r_wr + Q_AW'(i_cnt);
            if (pop_n[0]) r_rd <= r_rd + 1'b1;
            r_fill <= n_fill;
        end
    end

endmodule

FILE: src/gcode_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcode_line_tokenizer: G-code line lexer with XOR checksum
// Top level joining the byte lexer and the token output queue.
// ----------------------------------------------------------------------------
// Input channel: one byte per beat (i_char_byte, i_line_end), valid/stall.
// Output channel: one token per beat, valid/stall; o_last_result marks the
// last token caused by a byte.
// A byte is lexed in the cycle it is accepted; its tokens are registered in
// an 8-entry queue and drain at one token per cycle while i_stall is low.
// A byte is taken every cycle while the queue has room for five
// tokens, so the rate is one byte per cycle until the token stream, at one
// token per cycle on the output port, backs up the queue.
// Reset (synchronous, active low) empties the queue and returns the lexer to
// the start of a line. When the receiver stalls, the head token holds and
// the input stall rises once the queue can no longer take a full bundle.
// ----------------------------------------------------------------------------
module gcode_line_tokenizer import glt_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_char_byte,
    input  logic                        i_line_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [3:0]                  o_token_kind,
    output logic [6:0]                  o_letter,
    output logic signed [MANT_BITS-1:0] o_mantissa,
    output logic [3:0]                  o_frac_digits,
    output logic [7:0]                  o_calc_checksum,
    output logic                        o_last_result
);

    t_token [4:0] tok;
    t_token       head;
    logic [2:0]   cnt;
    logic         room, take;

    assign take    = i_valid && room;
    assign o_stall = !room;

    glt_lexer u_lex (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_char(i_char_byte), .i_end(i_line_end), .o_tok(tok), .o_cnt(cnt)
    );

    glt_queue u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(take), .i_tok(tok), .i_cnt(cnt),
        .o_room(room), .o_valid(o_valid), .o_tok(head), .i_pop(!i_stall)
    );

    assign o_token_kind    = head.kind;
    assign o_letter        = head.letter;
    assign o_mantissa      = head.mantissa;
    assign o_frac_digits   = head.frac;
    assign o_calc_checksum = head.csum;
    assign o_last_result   = head.last;

endmodule
